// ----- hdl/rbs_pkg.sv -----
// shared types, constants and helpers for the ray box slab test
package rbs_pkg;

    localparam int AXES      = 3;
    localparam int RAY_AXES  = 3;
    localparam int AXIS_W    = 2;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = 1;
    localparam int QCNT_W    = 2;
    localparam int DIV_STEPS = 33;
    localparam int DCNT_W    = 6;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TEST = 1'b1;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic                           action;
        logic [RAY_AXES-1:0][31:0]      pa;
        logic [RAY_AXES-1:0][31:0]      pb;
        logic [31:0]                    ts;
        logic [31:0]                    te;
    } rbs_req_t;

    typedef struct packed {
        logic        start;
        logic [31:0] d;
    } rbs_div_cmd_t;

    typedef struct packed {
        logic        done;
        logic [31:0] inv;
    } rbs_div_rsp_t;

    // floor-shifted product saturated to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
        logic signed [31:0] r;
        if (v > 49'sd2147483647)
            r = S32_MAX;
        else if (v < -49'sd2147483648)
            r = S32_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ----- hdl/ray_box_slab_test.sv -----
// top level of the ray against axis-aligned box slab test
//
// input channel: in_valid / in_stall with action and the point and interval fields.
// action load stores a ray (origin, reciprocal direction, interval) and gives no
// result; action test checks a box given by its min and max corners.
// output channel: out_valid / out_stall carrying hit, one per test request.
// a two-entry request queue sits in front of the execution side.
// a test passes the s1, s2 and s3 registers and then the hit register;
// tests run one per cycle while the pipeline is not held and no load is busy.
// a load occupies the shared bit-serial reciprocal unit for each axis in turn,
// one quotient bit per cycle, and first waits for tests in flight.
// reset clears the ray to zero, so a test before any load misses.
// when out_stall is high with a result waiting, the whole test pipeline holds
// and the queue fills, then in_stall rises.
module ray_box_slab_test
    import rbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [31:0] point_a_x,
    input  logic [31:0] point_a_y,
    input  logic [31:0] point_a_z,
    input  logic [31:0] point_b_x,
    input  logic [31:0] point_b_y,
    input  logic [31:0] point_b_z,
    input  logic [31:0] interval_start,
    input  logic [31:0] interval_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        hit
);

    rbs_req_t     in_req;
    rbs_req_t     q_head;
    logic         q_valid;
    logic         q_pop;
    rbs_div_cmd_t div_cmd;
    rbs_div_rsp_t div_rsp;

    always_comb
    begin
        in_req.action = action;
        in_req.pa     = {point_a_z, point_a_y, point_a_x};
        in_req.pb     = {point_b_z, point_b_y, point_b_x};
        in_req.ts     = interval_start;
        in_req.te     = interval_end;
    end

    rbs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_req   (in_req),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop)
    );

    rbs_recip u_recip (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .rsp   (div_rsp)
    );

    rbs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .div_cmd   (div_cmd),
        .div_rsp   (div_rsp),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .hit       (hit)
    );

endmodule

// ----- hdl/rbs_front.sv -----
// input side: accepts requests into a short queue
module rbs_front
    import rbs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  rbs_req_t in_req,
    output logic     q_valid,
    output rbs_req_t q_head,
    input  logic     q_pop
);

    rbs_req_t            entry_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   cnt_reg;
    logic                push;
    logic                pop;

    assign in_stall = (cnt_reg == QCNT_W'(QDEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_head   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

// ----- hdl/rbs_recip.sv -----
// bit-serial reciprocal 2^32 / d with saturation
module rbs_recip
    import rbs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  rbs_div_cmd_t cmd,
    output rbs_div_rsp_t rsp
);

    logic                busy_reg;
    logic [DCNT_W-1:0]   cnt_reg;
    logic [31:0]         mag_reg;
    logic                neg_reg;
    logic [31:0]         rem_reg;
    logic [32:0]         q_reg;
    logic                done_reg;
    logic [31:0]         inv_reg;
    logic [32:0]         rem_sh;
    logic                ge;
    logic [32:0]         q_next;
    logic [31:0]         inv_next;

    always_comb
    begin
        rem_sh = {rem_reg, (cnt_reg == '0)};
        ge     = (rem_sh >= {1'b0, mag_reg});
        q_next = {q_reg[31:0], ge};
        if (neg_reg)
        begin
            if (q_next > 33'h0_8000_0000)
                inv_next = S32_MIN;
            else
                inv_next = 32'(-q_next);
        end
        else
        begin
            // a zero divisor ends with all ones and saturates high
            if (q_next > 33'h0_7FFF_FFFF)
                inv_next = S32_MAX;
            else
                inv_next = q_next[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            mag_reg <= cmd.d[31] ? 32'(-cmd.d) : cmd.d;
            neg_reg <= cmd.d[31];
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? 32'(rem_sh - {1'b0, mag_reg}) : rem_sh[31:0];
            q_reg   <= q_next;
        end
        if (busy_reg && cnt_reg == DCNT_W'(DIV_STEPS - 1))
            inv_reg <= inv_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == DCNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.inv  = inv_reg;

endmodule

// ----- hdl/rbs_back.sv -----
// execution side: ray state, reciprocal sequencing and the slab pipeline
module rbs_back
    import rbs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  rbs_req_t     q_head,
    output logic         q_pop,
    output rbs_div_cmd_t div_cmd,
    input  rbs_div_rsp_t div_rsp,
    output logic         out_valid,
    input  logic         out_stall,
    output logic         hit
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DIV  = 1'b1;

    logic               state_reg;
    logic [AXIS_W-1:0]  axis_reg;
    logic               start_reg;
    logic signed [31:0] origin_reg [RAY_AXES];
    logic signed [31:0] inv_reg    [RAY_AXES];
    logic [31:0]        dir_reg    [RAY_AXES];
    logic signed [31:0] ts_reg;
    logic signed [31:0] te_reg;

    logic               s1_valid_reg;
    logic signed [32:0] da_reg [AXES];
    logic signed [32:0] db_reg [AXES];
    logic               s2_valid_reg;
    logic signed [64:0] pa_reg [AXES];
    logic signed [64:0] pb_reg [AXES];
    logic               s3_valid_reg;
    logic signed [31:0] t0_reg [AXES];
    logic signed [31:0] t1_reg [AXES];
    logic               out_valid_reg;
    logic               hit_reg;

    logic               adv;
    logic               pipe_busy;
    logic               pop_test;
    logic               pop_load;
    logic signed [31:0] tlo;
    logic signed [31:0] thi;

    assign adv       = !out_valid_reg || !out_stall;
    assign pipe_busy = s1_valid_reg || s2_valid_reg || s3_valid_reg;
    assign pop_test  = q_valid && q_head.action == ACT_TEST && state_reg == ST_IDLE && adv;
    // a load waits for tests in flight, they still read the old ray
    assign pop_load  = q_valid && q_head.action == ACT_LOAD && state_reg == ST_IDLE
                       && !pipe_busy;
    assign q_pop     = pop_test || pop_load;

    assign div_cmd.start = start_reg;
    assign div_cmd.d     = dir_reg[axis_reg];

    always_comb
    begin
        tlo = ts_reg;
        thi = te_reg;
        for (int i = 0; i < AXES; i++)
        begin
            if (t0_reg[i] > tlo)
                tlo = t0_reg[i];
            if (t1_reg[i] < thi)
                thi = t1_reg[i];
        end
    end

    // ray state and reciprocal sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            axis_reg  <= '0;
            start_reg <= 1'b0;
            ts_reg    <= '0;
            te_reg    <= '0;
            for (int i = 0; i < RAY_AXES; i++)
            begin
                origin_reg[i] <= '0;
                inv_reg[i]    <= '0;
                dir_reg[i]    <= '0;
            end
        end
        else
        begin
            start_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop_load)
                    begin
                        for (int i = 0; i < RAY_AXES; i++)
                        begin
                            origin_reg[i] <= q_head.pa[i];
                            dir_reg[i]    <= q_head.pb[i];
                        end
                        ts_reg    <= q_head.ts;
                        te_reg    <= q_head.te;
                        axis_reg  <= '0;
                        start_reg <= 1'b1;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        inv_reg[axis_reg] <= div_rsp.inv;
                        if (axis_reg == AXIS_W'(RAY_AXES - 1))
                            state_reg <= ST_IDLE;
                        else
                        begin
                            axis_reg  <= axis_reg + 1'b1;
                            start_reg <= 1'b1;
                        end
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // slab pipeline datapath
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                da_reg[i] <= 33'(signed'(q_head.pa[i])) - 33'(origin_reg[i]);
                db_reg[i] <= 33'(signed'(q_head.pb[i])) - 33'(origin_reg[i]);
                pa_reg[i] <= 65'(da_reg[i]) * 65'(inv_reg[i]);
                pb_reg[i] <= 65'(db_reg[i]) * 65'(inv_reg[i]);
                if (inv_reg[i] < 0)
                begin
                    t0_reg[i] <= sat32(pb_reg[i][64:16]);
                    t1_reg[i] <= sat32(pa_reg[i][64:16]);
                end
                else
                begin
                    t0_reg[i] <= sat32(pa_reg[i][64:16]);
                    t1_reg[i] <= sat32(pb_reg[i][64:16]);
                end
            end
            hit_reg <= (thi > tlo);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= pop_test;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;

endmodule

// ----- hdl/rbs_checker.sv -----
// port-level checks for the ray box slab test, bound to the top level
module rbs_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic hit
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_hit_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(hit))
        else $error("hit changed while stalled");

    // the queue only fills after a request was taken
    a_stall_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid && !in_stall))
        else $error("in_stall rose without a request");

    a_reset_clear: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid && !in_stall)
        else $error("state not cleared by reset");

endmodule

bind ray_box_slab_test rbs_checker u_rbs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hit       (hit)
);

// ----- dv/tb.sv -----
// testbench for the ray box slab test: queued requests, predicted hits, checked in order
`timescale 1ns / 100ps

module tb;
    import rbs_pkg::*;

    typedef struct {
        logic               action;
        logic signed [31:0] pa [3];
        logic signed [31:0] pb [3];
        logic signed [31:0] ts;
        logic signed [31:0] te;
    } request_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        action;
    logic [31:0] point_a_x, point_a_y, point_a_z;
    logic [31:0] point_b_x, point_b_y, point_b_z;
    logic [31:0] interval_start, interval_end;
    logic        out_valid;
    logic        out_stall;
    logic        hit;

    ray_box_slab_test DUT (.*);

    request_t pending_requests[$];
    logic     expected_hits[$];

    // predictor copy of the stored ray
    logic signed [63:0] ray_org [3];
    logic signed [63:0] ray_inv [3];
    logic signed [63:0] ray_lo, ray_hi;

    int  error_count;
    int  cycle_count;
    int  send_idle_pct, recv_idle_pct;
    int  hold_off;
    bit  hold_go;
    bit  hold_used;

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic signed [63:0] reciprocal(input logic signed [63:0] d);
        logic [63:0] mag;
        logic [63:0] q;
        if (d == 0) return 64'sd2147483647;
        mag = (d < 0) ? -d : d;
        q = 64'h1_0000_0000 / mag;
        if (d > 0) return (q > 64'h7FFF_FFFF) ? 64'sd2147483647 : $signed(q);
        if (q > 64'h8000_0000) return -64'sd2147483648;
        return -$signed(q);
    endfunction

    function automatic logic signed [63:0] slab_dist(input logic signed [63:0] diff,
                                                     input logic signed [63:0] inv);
        logic signed [63:0] p;
        p = diff * inv;
        return clamp32(p >>> 16);
    endfunction

    // updates the ray on a load, pushes the expected hit on a test
    task automatic predict_request(input request_t r);
        logic signed [63:0] lo, hi, t0, t1, tmp;
        logic               h;
        h = 1'b1;
        if (r.action == ACT_LOAD)
        begin
            for (int a = 0; a < 3; a++)
            begin
                ray_org[a] = r.pa[a];
                ray_inv[a] = reciprocal(r.pb[a]);
            end
            ray_lo = r.ts;
            ray_hi = r.te;
        end
        else
        begin
            lo = ray_lo;
            hi = ray_hi;
            for (int a = 0; a < AXES; a++)
            begin
                if (h)
                begin
                    t0 = slab_dist(r.pa[a] - ray_org[a], ray_inv[a]);
                    t1 = slab_dist(r.pb[a] - ray_org[a], ray_inv[a]);
                    if (ray_inv[a] < 0)
                    begin
                        tmp = t0; t0 = t1; t1 = tmp;
                    end
                    if (t0 > lo) lo = t0;
                    if (t1 < hi) hi = t1;
                    if (hi <= lo) h = 1'b0;
                end
            end
            expected_hits.push_back(h);
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 4) - 2;
            default: return $urandom;
        endcase
    endfunction

    function automatic request_t make_load(input logic signed [31:0] o,
                                           input logic signed [31:0] d,
                                           input logic signed [31:0] s,
                                           input logic signed [31:0] e);
        request_t r;
        r.action = ACT_LOAD;
        for (int a = 0; a < 3; a++)
        begin
            r.pa[a] = o; r.pb[a] = d;
        end
        r.ts = s; r.te = e;
        return r;
    endfunction

    function automatic request_t make_box(input logic signed [31:0] lo,
                                          input logic signed [31:0] hi);
        request_t r;
        r.action = ACT_TEST;
        for (int a = 0; a < 3; a++)
        begin
            r.pa[a] = lo; r.pb[a] = hi;
        end
        r.ts = $urandom; r.te = $urandom;
        return r;
    endfunction

    // ray near the origin with moderate direction, so boxes really get hit or missed
    function automatic request_t random_ray();
        request_t r;
        r.action = ACT_LOAD;
        for (int a = 0; a < 3; a++)
        begin
            r.pa[a] = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
            r.pb[a] = ($urandom_range(0, 9) == 0) ? rand_word()
                    : $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        end
        r.ts = ($urandom_range(0, 7) == 0) ? rand_word()
             : 32'(-$urandom_range(0, 32'h0001_0000));
        r.te = ($urandom_range(0, 7) == 0) ? rand_word() : $urandom_range(0, 32'h0100_0000);
        return r;
    endfunction

    function automatic request_t random_box();
        request_t r;
        logic signed [31:0] c, w;
        r.action = ACT_TEST;
        for (int a = 0; a < 3; a++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                r.pa[a] = rand_word(); r.pb[a] = rand_word();
            end
            else
            begin
                c = $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
                w = $urandom_range(0, 32'h0020_0000);
                r.pa[a] = c - w; r.pb[a] = c + w;
            end
        end
        r.ts = $urandom; r.te = $urandom;
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            action <= ACT_LOAD;
            {point_a_x, point_a_y, point_a_z} <= '0;
            {point_b_x, point_b_y, point_b_z} <= '0;
            interval_start <= '0;
            interval_end <= '0;
            // the stored ray starts out all zero
            for (int a = 0; a < 3; a++)
            begin
                ray_org[a] = '0;
                ray_inv[a] = '0;
            end
            ray_lo = '0;
            ray_hi = '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_request(pending_requests.pop_front());
            end
            if ((in_valid && !in_stall) || !in_valid)
            begin
                if (pending_requests.size() > 0
                    && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    action <= pending_requests[0].action;
                    point_a_x <= pending_requests[0].pa[0];
                    point_a_y <= pending_requests[0].pa[1];
                    point_a_z <= pending_requests[0].pa[2];
                    point_b_x <= pending_requests[0].pb[0];
                    point_b_y <= pending_requests[0].pb[1];
                    point_b_z <= pending_requests[0].pb[2];
                    interval_start <= pending_requests[0].ts;
                    interval_end <= pending_requests[0].te;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall, with a counted long hold-off when asked
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_go && !hold_used)
        begin
            hold_used <= 1'b1;
            hold_off <= 59;
            out_stall <= 1'b1;
        end
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_hits.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result hit=%0b", hit));
            end
            else
            begin
                if (hit !== expected_hits[0])
                    report_mismatch($sformatf("hit got %0b expected %0b",
                                              hit, expected_hits[0]));
                void'(expected_hits.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("timeout");
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic drain();
        while (pending_requests.size() > 0 || in_valid || expected_hits.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        request_t r;
        hold_go = 0;
        send_idle_pct = 36;
        recv_idle_pct = 74;
        // test before any load misses
        pending_requests.push_back(make_box(32'sh8000_0000, 32'sh7FFF_FFFF));
        pending_requests.push_back(make_load(0, 32'sh0001_0000, 0, 32'sh7FFF_FFFF));
        pending_requests.push_back(make_box(32'sh0000_1000, 32'sh0002_0000));
        pending_requests.push_back(make_box(32'sh8000_0000, 32'sh7FFF_FFFF));
        pending_requests.push_back(make_box(-32'sh0002_0000, -32'sh0001_0000));
        // zero direction, saturated reciprocal
        pending_requests.push_back(make_load(0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF));
        pending_requests.push_back(make_box(-32'sh0000_0001, 32'sh0000_0001));
        pending_requests.push_back(make_box(32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        // negative direction swaps slab ends
        pending_requests.push_back(make_load(0, -32'sh0001_0000, 32'sh8000_0000,
                                             32'sh7FFF_FFFF));
        pending_requests.push_back(make_box(-32'sh0003_0000, -32'sh0001_0000));
        pending_requests.push_back(make_box(32'sh8000_0000, 32'sh7FFF_FFFF));
        // tiny directions saturate, extreme min direction
        pending_requests.push_back(make_load(32'sh7FFF_FFFF, 32'sh0000_0001, 0,
                                             32'sh0001_0000));
        pending_requests.push_back(make_box(32'sh8000_0000, 32'sh7FFF_FFFF));
        pending_requests.push_back(make_load(32'sh8000_0000, 32'sh8000_0000,
                                             32'sh8000_0000, 32'sh7FFF_FFFF));
        pending_requests.push_back(make_box(32'sh8000_0000, 32'sh7FFF_FFFF));
        pending_requests.push_back(make_load(0, -32'sh0000_0001, 32'sh0001_0000,
                                             32'sh0001_0000));
        pending_requests.push_back(make_box(-32'sh0001_0000, 32'sh0001_0000));
        for (int i = 0; i < 1750; i++)
        begin
            if (i == 1200)
            begin
                drain();
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (i == 600)
            begin
                drain();
                send_idle_pct = 74;
                recv_idle_pct = 36;
            end
            if (i == 1300)
                hold_go = 1;
            r = ($urandom_range(0, 19) == 0) ? random_ray() : random_box();
            pending_requests.push_back(r);
        end
        drain();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/rbs_pkg.sv
hdl/rbs_front.sv
hdl/rbs_recip.sv
hdl/rbs_back.sv
hdl/ray_box_slab_test.sv
hdl/rbs_checker.sv
dv/tb.sv
